@@ hdl/rsd_pkg.sv @@
`default_nettype none

package rsd_pkg;

  // Decoder phase: what the next compressed element means
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_RUN    = 2'd1,
    PH_LIT    = 2'd2
  } rsd_phase_e;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_OVERRUN = 2'd2;

  // Input command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ELEMENT = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_ELEMENT_BYTES = 2'd0;
  localparam logic [1:0] CFG_SWAP_BYTES    = 2'd1;
  localparam logic [1:0] CFG_LINE_WIDTH    = 2'd2;

  // element_bytes value that selects 16-bit elements
  localparam logic [1:0] BYTES_WIDE = 2'd2;

  // Header fields
  localparam logic [6:0] COUNT_MASK = 7'h7f;
  localparam int unsigned LIT_FLAG_BIT = 7;

  // Per-result control fields carried through the queue
  typedef struct packed {
    logic [6:0] repeat_count;
    logic       line_done;
    logic [1:0] status;
  } rsd_meta_t;

endpackage

`default_nettype wire

@@ hdl/sgi_rle_scanline_decoder.sv @@
// out_valid rises once a result has passed through the queue and the output register.
// Throughput: one element per cycle while the queue is not full; the front
// parser updates its line state on each transfer, and a two-entry queue feeds
// the output register. Input ready drops only while the queue is full.
// Reset (asynchronous, active low): no line open, registers at
// element_bytes 1, swap_bytes 0, line_width 1, queue and output empty.
`default_nettype none

module sgi_rle_scanline_decoder #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // compressed elements
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [15:0] element_i,
  input  wire logic        data_end_i,
  // decoded results
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      pixel_value_o,
  output logic [6:0]       repeat_count_o,
  output logic             line_done_o,
  output logic [1:0]       status_o
);

  import rsd_pkg::*;

  localparam int unsigned MetaW  = $bits(rsd_meta_t);
  localparam int unsigned EntryW = ELEMENT_BITS + MetaW;

  logic [1:0]  elem_bytes_q;
  logic        swap_q;
  logic [15:0] line_width_q;
  logic        wide;

  logic                    accept;
  logic                    push;
  logic [ELEMENT_BITS-1:0] f_value;
  rsd_meta_t               f_meta;
  logic                    q_full;
  logic                    q_valid;
  logic                    q_pop;
  logic [EntryW-1:0]       q_wdata;
  logic [EntryW-1:0]       q_rdata;
  rsd_meta_t               q_meta;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_bytes_q <= 2'd1;
      swap_q       <= 1'b0;
      line_width_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ELEMENT_BYTES: elem_bytes_q <= cfg_data_i[1:0];
        CFG_SWAP_BYTES:    swap_q       <= cfg_data_i[0];
        CFG_LINE_WIDTH:    line_width_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign wide       = (elem_bytes_q == BYTES_WIDE);
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  rsd_front #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .cmd_i       (cmd_i),
    .element_i   (element_i),
    .data_end_i  (data_end_i),
    .wide_i      (wide),
    .line_width_i(line_width_q),
    .push_o      (push),
    .value_o     (f_value),
    .meta_o      (f_meta)
  );

  assign q_wdata = {f_value, f_meta};

  rsd_fifo #(
    .WIDTH(EntryW),
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign q_meta = q_rdata[MetaW-1:0];

  rsd_back #(
    .ELEMENT_BITS(ELEMENT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_value_i     (q_rdata[EntryW-1:MetaW]),
    .q_meta_i      (q_meta),
    .q_pop_o       (q_pop),
    .swap_i        (wide && swap_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .repeat_count_o(repeat_count_o),
    .line_done_o   (line_done_o),
    .status_o      (status_o)
  );

endmodule

`default_nettype wire

@@ hdl/rsd_fifo.sv @@
`default_nettype none

module rsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsd_front.sv @@
`default_nettype none

module rsd_front #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    accept_i,
  input  wire logic                    cmd_i,
  input  wire logic [15:0]             element_i,
  input  wire logic                    data_end_i,
  input  wire logic                    wide_i,
  input  wire logic [15:0]             line_width_i,
  output logic                         push_o,
  output logic [ELEMENT_BITS-1:0]      value_o,
  output rsd_pkg::rsd_meta_t           meta_o
);

  import rsd_pkg::*;

  localparam logic [ELEMENT_BITS-1:0] ByteMask = ELEMENT_BITS'(8'hff);

  rsd_phase_e        phase_q, phase_d;
  logic [6:0]        pend_q, pend_d;
  logic [15:0]       pw_q, pw_d;
  logic              closed_q, closed_d;

  logic [ELEMENT_BITS-1:0] elem_m;
  logic [6:0]        hdr_count;
  logic              hdr_lit;
  logic [15:0]       remaining;
  logic [6:0]        rep;
  logic [16:0]       pw_sum;
  logic [6:0]        pend_dec;
  logic              line_full;
  logic              live;

  // element masked to the active element size
  assign elem_m    = wide_i ? element_i[ELEMENT_BITS-1:0]
                            : (element_i[ELEMENT_BITS-1:0] & ByteMask);
  assign hdr_count = elem_m[6:0] & COUNT_MASK;
  assign hdr_lit   = elem_m[LIT_FLAG_BIT];
  assign remaining = (line_width_i > pw_q) ? (line_width_i - pw_q) : 16'd0;
  assign pend_dec  = (pend_q != 7'd0) ? (pend_q - 7'd1) : 7'd0;
  assign live      = accept_i && (cmd_i == CMD_ELEMENT) && !closed_q;

  // repeat for a value element, clipped to what is left of the line
  always_comb begin
    if (phase_q == PH_LIT) begin
      rep = (remaining != 16'd0) ? 7'd1 : 7'd0;
    end else if ({9'd0, pend_q} > remaining) begin
      rep = remaining[6:0];
    end else begin
      rep = pend_q;
    end
  end

  assign pw_sum    = {1'b0, pw_q} + {10'd0, rep};
  assign line_full = (pw_sum >= {1'b0, line_width_i});

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i && (cmd_i == CMD_START)) begin
      phase_d = PH_HEADER;
    end else if (live) begin
      unique case (phase_q)
        PH_RUN: phase_d = PH_HEADER;
        PH_LIT: phase_d = (pend_dec == 7'd0) ? PH_HEADER : PH_LIT;
        default: begin
          if (hdr_count == 7'd0) begin
            phase_d = PH_HEADER;
          end else begin
            phase_d = hdr_lit ? PH_LIT : PH_RUN;
          end
        end
      endcase
    end
  end

  // counters, line state and result
  always_comb begin
    pend_d   = pend_q;
    pw_d     = pw_q;
    closed_d = closed_q;
    push_o   = 1'b0;
    value_o  = '0;
    meta_o   = '0;
    if (accept_i && (cmd_i == CMD_START)) begin
      pend_d   = 7'd0;
      pw_d     = 16'd0;
      closed_d = 1'b0;
    end else if (live) begin
      unique case (phase_q)
        PH_RUN: begin
          push_o              = 1'b1;
          value_o             = elem_m;
          meta_o.repeat_count = rep;
          meta_o.status       = ST_OK;
          if ({9'd0, pend_q} > remaining) begin
            meta_o.status    = ST_OVERRUN;
            meta_o.line_done = 1'b1;
          end
          pw_d   = pw_sum[15:0];
          pend_d = 7'd0;
          if (line_full) begin
            meta_o.line_done = 1'b1;
          end else if (data_end_i) begin
            meta_o.line_done = 1'b1;
            meta_o.status    = ST_SHORT;
          end
        end
        PH_LIT: begin
          push_o              = 1'b1;
          value_o             = elem_m;
          meta_o.repeat_count = rep;
          meta_o.status       = (rep != 7'd0) ? ST_OK : ST_OVERRUN;
          meta_o.line_done    = (rep == 7'd0);
          pw_d   = pw_sum[15:0];
          pend_d = pend_dec;
          if (line_full) begin
            meta_o.line_done = 1'b1;
            if (pend_dec != 7'd0) begin
              meta_o.status = ST_OVERRUN;
            end
          end else if (data_end_i) begin
            meta_o.line_done = 1'b1;
            meta_o.status    = ST_SHORT;
          end
        end
        default: begin
          // header: zero count ends the line, data_end means data is missing
          pend_d = hdr_count;
          if (hdr_count == 7'd0) begin
            push_o           = 1'b1;
            meta_o.line_done = 1'b1;
            meta_o.status    = ST_OK;
          end else if (data_end_i) begin
            push_o           = 1'b1;
            meta_o.line_done = 1'b1;
            meta_o.status    = ST_SHORT;
          end
        end
      endcase
      if (push_o && meta_o.line_done) begin
        closed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      pend_q   <= 7'd0;
      pw_q     <= 16'd0;
      closed_q <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      pend_q   <= pend_d;
      pw_q     <= pw_d;
      closed_q <= closed_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsd_back.sv @@
`default_nettype none

module rsd_back #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    q_valid_i,
  input  wire logic [ELEMENT_BITS-1:0] q_value_i,
  input  wire rsd_pkg::rsd_meta_t      q_meta_i,
  output logic                         q_pop_o,
  input  wire logic                    swap_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [15:0]                  pixel_value_o,
  output logic [6:0]                   repeat_count_o,
  output logic                         line_done_o,
  output logic [1:0]                   status_o
);

  import rsd_pkg::*;

  logic        valid_q;
  logic [15:0] value_q;
  rsd_meta_t   meta_q;
  logic [15:0] value_ext;
  logic [15:0] value_d;

  // refill the output register when empty or being drained
  assign q_pop_o = q_valid_i && (!valid_q || out_ready_i);

  // widen and optionally swap bytes
  always_comb begin
    value_ext = '0;
    value_ext[ELEMENT_BITS-1:0] = q_value_i;
    value_d = swap_i ? {value_ext[7:0], value_ext[15:8]} : value_ext;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      value_q <= value_d;
      meta_q  <= q_meta_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign pixel_value_o  = value_q;
  assign repeat_count_o = meta_q.repeat_count;
  assign line_done_o    = meta_q.line_done;
  assign status_o       = meta_q.status;

endmodule

`default_nettype wire

@@ tb/sgi_rle_scanline_monitor.sv @@
`default_nettype none

module sgi_rle_scanline_monitor #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration channel
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  // element channel
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic        cmd_i,
  input  wire logic [15:0] element_i,
  input  wire logic        data_end_i,
  // result channel
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [15:0] pixel_value_i,
  input  wire logic [6:0]  repeat_count_i,
  input  wire logic        line_done_i,
  input  wire logic [1:0]  status_i,
  // towards the testbench top
  output int               fail_count_o,
  output int               pending_o
);

  import rsd_pkg::*;

  localparam logic [15:0] WIDE_MASK = 16'((32'd1 << ELEMENT_BITS) - 1);

  typedef struct packed {
    logic [15:0] pixel;
    logic [6:0]  rep;
    logic        done;
    logic [1:0]  status;
  } pixel_run_t;

  // Runs still owed by the decoder, oldest first
  pixel_run_t  expected_runs[$];

  // Register copies
  logic [1:0]  elem_bytes;
  logic        swap_on;
  logic [15:0] width_px;

  // Line state
  rsd_phase_e  line_phase;
  logic [6:0]  pend_count;
  int unsigned pix_written;
  logic        line_shut;

  task automatic report_fault(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  // Decode one element transfer; returns 1 when it produces a run
  function automatic bit decode_element(input logic cmd, input logic [15:0] elem,
                                        input logic dend, output pixel_run_t res);
    logic [15:0] e;
    logic [15:0] val;
    int unsigned left;
    int unsigned rep;
    logic        done;
    logic [1:0]  st;
    res = '0;
    if (cmd == CMD_START) begin
      line_phase  = PH_HEADER;
      pend_count  = '0;
      pix_written = 0;
      line_shut   = 1'b0;
      return 1'b0;
    end
    if (line_shut) return 1'b0;

    e    = (elem_bytes == BYTES_WIDE) ? (elem & WIDE_MASK) : {8'h00, elem[7:0]};
    val  = (elem_bytes == BYTES_WIDE && swap_on) ? {e[7:0], e[15:8]} : e;
    left = (width_px > pix_written) ? width_px - pix_written : 0;

    case (line_phase)
      PH_RUN: begin
        rep  = pend_count;
        st   = ST_OK;
        done = 1'b0;
        // clip to what is left of the line
        if (rep > left) begin
          rep  = left;
          st   = ST_OVERRUN;
          done = 1'b1;
        end
        pix_written += rep;
        if (pix_written >= width_px) begin
          done = 1'b1;
        end else if (dend) begin
          done = 1'b1;
          st   = ST_SHORT;
        end
        pend_count = '0;
        line_phase = PH_HEADER;
      end
      PH_LIT: begin
        rep  = (left > 0) ? 1 : 0;
        st   = (rep != 0) ? ST_OK : ST_OVERRUN;
        done = (rep == 0);
        pix_written += rep;
        if (pend_count != 0) pend_count--;
        if (pix_written >= width_px) begin
          done = 1'b1;
          if (pend_count != 0) st = ST_OVERRUN;
        end else if (dend) begin
          done = 1'b1;
          st   = ST_SHORT;
        end
        if (pend_count == 0) line_phase = PH_HEADER;
      end
      default: begin
        // header: count in low bits, literal flag above
        pend_count = e[6:0] & COUNT_MASK;
        if (pend_count == 0) begin
          line_phase = PH_HEADER;
          res.done   = 1'b1;
          res.status = ST_OK;
          line_shut  = 1'b1;
          return 1'b1;
        end
        line_phase = e[LIT_FLAG_BIT] ? PH_LIT : PH_RUN;
        if (dend) begin
          res.done   = 1'b1;
          res.status = ST_SHORT;
          line_shut  = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
    endcase

    res.pixel  = val;
    res.rep    = rep[6:0];
    res.done   = done;
    res.status = st;
    if (done) line_shut = 1'b1;
    return 1'b1;
  endfunction

  // Watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_run_t fresh;
    pixel_run_t got;
    pixel_run_t want;
    if (!rst_ni) begin
      expected_runs.delete();
      elem_bytes   = 2'd1;
      swap_on      = 1'b0;
      width_px     = 16'd1;
      line_phase   = PH_HEADER;
      pend_count   = '0;
      pix_written  = 0;
      line_shut    = 1'b1;
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ELEMENT_BYTES: elem_bytes = cfg_data_i[1:0];
          CFG_SWAP_BYTES:    swap_on    = cfg_data_i[0];
          CFG_LINE_WIDTH:    width_px   = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (decode_element(cmd_i, element_i, data_end_i, fresh))
          expected_runs.push_back(fresh);
      end

      if (out_valid_i && out_ready_i) begin
        got.pixel  = pixel_value_i;
        got.rep    = repeat_count_i;
        got.done   = line_done_i;
        got.status = status_i;
        if (expected_runs.size() == 0) begin
          report_fault($sformatf("unexpected result value %h rep %0d done %b status %0d",
                                 got.pixel, got.rep, got.done, got.status));
        end else begin
          want = expected_runs.pop_front();
          if (got.pixel !== want.pixel)
            report_fault($sformatf("pixel_value %h, want %h", got.pixel, want.pixel));
          if (got.rep !== want.rep)
            report_fault($sformatf("repeat_count %0d, want %0d", got.rep, want.rep));
          if (got.done !== want.done)
            report_fault($sformatf("line_done %b, want %b", got.done, want.done));
          if (got.status !== want.status)
            report_fault($sformatf("status %0d, want %0d", got.status, want.status));
        end
      end

      pending_o <= expected_runs.size();
    end
  end

endmodule

`default_nettype wire

@@ tb/sgi_rle_scanline_decoder_tb.sv @@
`default_nettype none

module sgi_rle_scanline_decoder_tb;

  import rsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 125;
  // index with no register behind it
  localparam logic [1:0]  CFG_SPARE   = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        cmd        = CMD_START;
  logic [15:0] element    = '0;
  logic        data_end   = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [15:0] pixel_value;
  logic [6:0]  repeat_count;
  logic        line_done;
  logic [1:0]  status;

  int          fail_count;
  int          pending;
  int unsigned items_sent   = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_tickets = 0;
  int unsigned hold_served  = 0;
  int unsigned cycle_count  = 0;

  sgi_rle_scanline_decoder dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .cmd_i          (cmd),
    .element_i      (element),
    .data_end_i     (data_end),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_value_o  (pixel_value),
    .repeat_count_o (repeat_count),
    .line_done_o    (line_done),
    .status_o       (status)
  );

  sgi_rle_scanline_monitor monitor (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .cmd_i          (cmd),
    .element_i      (element),
    .data_end_i     (data_end),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_value_i  (pixel_value),
    .repeat_count_i (repeat_count),
    .line_done_i    (line_done),
    .status_i       (status),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** sgi_rle_scanline_decoder: FAILED **");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_tickets != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // One element transfer; valid stays up on return
  task automatic send_item(input logic c, input logic [15:0] e, input logic d);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    element  <= e;
    data_end <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and wait until every owed run has arrived
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] nbytes, input logic swap, input logic [15:0] px);
    settle();
    write_reg(CFG_ELEMENT_BYTES, {14'($urandom), nbytes});
    write_reg(CFG_SWAP_BYTES, {15'($urandom), swap});
    write_reg(CFG_LINE_WIDTH, px);
  endtask

  // A mostly well-formed scanline with random content, plus some noise
  task automatic send_line(input int unsigned px);
    int unsigned covered;
    int unsigned n;
    int unsigned k;
    int unsigned headers;
    int unsigned r;
    logic        lit;
    logic        d;
    logic        stop;
    covered = 0;
    headers = 0;
    stop    = 1'b0;
    send_item(CMD_START, 16'($urandom), 1'($urandom));
    while (!stop && headers < 10) begin
      headers++;
      r = $urandom_range(99);
      if (r < 4) begin
        send_item(1'($urandom), 16'($urandom), 1'($urandom));
      end else if (r < 10) begin
        // zero count header closes the line
        send_item(CMD_ELEMENT, {8'($urandom), 1'($urandom), 7'd0}, 1'($urandom));
        stop = 1'b1;
      end else begin
        n   = ($urandom_range(7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
        lit = 1'($urandom);
        d   = ($urandom_range(39) == 0);
        send_item(CMD_ELEMENT, {8'($urandom), lit, 7'(n)}, d);
        if (d) begin
          stop = 1'b1;
        end else if (lit) begin
          for (k = 0; k < n && !stop; k++) begin
            d = ($urandom_range(59) == 0);
            send_item(CMD_ELEMENT, 16'($urandom), d);
            covered++;
            if (d || covered >= px) stop = 1'b1;
          end
        end else begin
          d = ($urandom_range(29) == 0);
          send_item(CMD_ELEMENT, 16'($urandom), d);
          covered += n;
          if (d || covered >= px) stop = 1'b1;
        end
      end
    end
    // trailing element, usually after the line has closed
    if ($urandom_range(4) == 0) send_item(CMD_ELEMENT, 16'($urandom), 1'($urandom));
  endtask

  task automatic run_phase(input logic [1:0] nbytes, input logic swap, input logic [15:0] px,
                           input int unsigned idle, input int unsigned stall, input bit hold);
    int unsigned stop_at;
    set_mode(nbytes, swap, px);
    idle_pct  <= idle;
    stall_pct <= stall;
    if (hold) hold_tickets <= hold_tickets + 1;
    stop_at = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) send_line(px);
  endtask

  // Directed cases: corners of the fields and every special case
  task automatic run_directed();
    int unsigned k;
    // reset mode: 8-bit, width 1
    send_item(CMD_ELEMENT, 16'h0203, 1'b0);   // no line open, ignored
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'hff03, 1'b0);   // run of 3, upper byte ignored
    send_item(CMD_ELEMENT, 16'habcd, 1'b0);   // clipped to 1, overrun
    settle();
    write_reg(CFG_SPARE, 16'hffff);
    set_mode(BYTES_WIDE, 1'b1, 16'd6);
    send_item(CMD_START, 16'hffff, 1'b1);
    send_item(CMD_ELEMENT, 16'hff82, 1'b0);   // two literals
    send_item(CMD_ELEMENT, 16'h1234, 1'b0);
    send_item(CMD_ELEMENT, 16'hffff, 1'b0);
    send_item(CMD_ELEMENT, 16'h0080, 1'b0);   // zero count ends the line
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'h0005, 1'b1);   // header with data ending
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'h007f, 1'b0);   // longest run, clipped
    send_item(CMD_ELEMENT, 16'h0000, 1'b0);
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'h0088, 1'b0);   // literals beyond the width
    for (k = 0; k < 6; k++) send_item(CMD_ELEMENT, 16'($urandom), 1'b0);
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'h0002, 1'b0);   // short run, data ends
    send_item(CMD_ELEMENT, 16'h5aa5, 1'b1);
    // zero width
    set_mode(BYTES_WIDE, 1'b0, 16'd0);
    send_item(CMD_START, 16'h0000, 1'b0);
    send_item(CMD_ELEMENT, 16'h0001, 1'b0);
    send_item(CMD_ELEMENT, 16'h8001, 1'b0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_phase(2'd1, 1'b0, 16'd20, 0, 0, 1'b0);
    run_phase(BYTES_WIDE, 1'b1, 16'd1, 85, 0, 1'b0);
    run_phase(BYTES_WIDE, 1'b0, 16'hffff, 0, 85, 1'b0);
    run_phase(2'd0, 1'b1, 16'd37, 16, 16, 1'b0);
    run_phase(2'd3, 1'b0, 16'd0, 0, 0, 1'b0);
    run_phase(BYTES_WIDE, 1'b1, 16'($urandom_range(2, 64)), 85, 0, 1'b0);
    run_phase(2'd1, 1'b1, 16'($urandom_range(2, 64)), 0, 85, 1'b0);
    run_phase(BYTES_WIDE, 1'b1, 16'd12, 0, 0, 1'b1);
    settle();
    if (fail_count == 0 && pending == 0)
      $display("** sgi_rle_scanline_decoder: PASSED **");
    else
      $display("** sgi_rle_scanline_decoder: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
